@@ hw/rtl/ans_pkg.sv @@
// shared constants, types and helpers for the annex b nal splitter
`default_nettype none

package ans_pkg;

    // parameter set store sizes
    localparam int SPS_DEPTH = 32;
    localparam int PPS_DEPTH = 16;

    localparam int SPS_AW = $clog2(SPS_DEPTH);
    localparam int PPS_AW = $clog2(PPS_DEPTH);
    localparam int SPS_LW = $clog2(SPS_DEPTH + 1);
    localparam int PPS_LW = $clog2(PPS_DEPTH + 1);
    localparam int REP_W  = (SPS_AW > PPS_AW) ? SPS_AW : PPS_AW;
    localparam int CMP_W  = REP_W + 1;

    // last index of a start code prefix
    localparam int PFX_LONG_LAST  = 3;
    localparam int PFX_SHORT_LAST = 2;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [1:0] ZERO_RUN_MAX  = 2'd3;

    localparam logic [4:0] TYPE_SLICE = 5'd1;
    localparam logic [4:0] TYPE_IDR   = 5'd5;
    localparam logic [4:0] TYPE_SPS   = 5'd7;
    localparam logic [4:0] TYPE_PPS   = 5'd8;

    typedef enum logic [4:0] {
        MODE_SKIP = 5'b00001,
        MODE_HEAD = 5'b00010,
        MODE_FWD  = 5'b00100,
        MODE_SPS  = 5'b01000,
        MODE_PPS  = 5'b10000
    } mode_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_START,
        OP_HEAD_ZERO,
        OP_HEAD_BEGIN,
        OP_HEAD_OTHER,
        OP_ZERO,
        OP_DELIV_ZERO,
        OP_DELIV_BYTE,
        OP_EMIT_LONG_PFX,
        OP_EMIT_SPS,
        OP_EMIT_PPS,
        OP_EMIT_PFX,
        OP_EMIT_HDR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;
    } cmd_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] zero_run;
        logic       sps_valid;
        logic       pps_valid;
        logic       slot_free;
        logic       rep_pfx4_end;
        logic       rep_sps_end;
        logic       rep_pps_end;
        logic       rep_pfx_end;
    } status_t;

    function automatic logic [4:0] nal_type(input logic [7:0] b);
        return 5'(b & NAL_TYPE_MASK);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ans_ctrl.sv @@
// sequencing state machine of the nal splitter
`default_nettype none

module ans_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [7:0]          s_data_byte,
    output logic                s_ready,
    input  ans_pkg::status_t    status,
    output ans_pkg::cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_DELIV    = 8'b00000010,
        ST_SPS_PFX  = 8'b00000100,
        ST_SPS_DATA = 8'b00001000,
        ST_PPS_PFX  = 8'b00010000,
        ST_PPS_DATA = 8'b00100000,
        ST_PFX      = 8'b01000000,
        ST_HDR      = 8'b10000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        is_sc;
    logic        is_idr;
    logic        is_fwd_type;

    assign is_sc  = (s_data_byte == ans_pkg::BYTE_ONE) && status.zero_run[1];
    assign is_idr = (ans_pkg::nal_type(s_data_byte) == ans_pkg::TYPE_IDR);

    always_comb begin
        is_fwd_type = ans_pkg::nal_type(s_data_byte)
                      inside {ans_pkg::TYPE_SLICE, ans_pkg::TYPE_IDR};
    end

    assign s_ready = (state_reg == ST_IDLE) && status.slot_free;

    always_comb begin
        state_next = state_reg;
        cmd.op     = ans_pkg::OP_NOP;
        cmd.take   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.slot_free) begin
                    cmd.take = 1'b1;
                    if (is_sc) begin
                        cmd.op = ans_pkg::OP_START;
                    end else if (status.mode == ans_pkg::MODE_HEAD) begin
                        if (s_data_byte == ans_pkg::BYTE_ZERO) begin
                            cmd.op = ans_pkg::OP_HEAD_ZERO;
                        end else if (is_fwd_type) begin
                            cmd.op = ans_pkg::OP_HEAD_BEGIN;
                            if (is_idr && status.sps_valid) begin
                                state_next = ST_SPS_PFX;
                            end else if (is_idr && status.pps_valid) begin
                                state_next = ST_PPS_PFX;
                            end else begin
                                state_next = ST_PFX;
                            end
                        end else begin
                            cmd.op = ans_pkg::OP_HEAD_OTHER;
                        end
                    end else if (s_data_byte == ans_pkg::BYTE_ZERO) begin
                        cmd.op = ans_pkg::OP_ZERO;
                    end else if (status.zero_run == 2'd0) begin
                        cmd.op = ans_pkg::OP_DELIV_BYTE;
                    end else begin
                        cmd.op     = ans_pkg::OP_DELIV_ZERO;
                        state_next = ST_DELIV;
                    end
                end
            end
            ST_DELIV: begin
                if (status.slot_free) begin
                    if (status.zero_run != 2'd0) begin
                        cmd.op = ans_pkg::OP_DELIV_ZERO;
                    end else begin
                        cmd.op     = ans_pkg::OP_DELIV_BYTE;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SPS_PFX: begin
                if (status.slot_free) begin
                    cmd.op = ans_pkg::OP_EMIT_LONG_PFX;
                    if (status.rep_pfx4_end) begin
                        state_next = ST_SPS_DATA;
                    end
                end
            end
            ST_SPS_DATA: begin
                if (status.slot_free) begin
                    cmd.op = ans_pkg::OP_EMIT_SPS;
                    if (status.rep_sps_end) begin
                        state_next = status.pps_valid ? ST_PPS_PFX : ST_PFX;
                    end
                end
            end
            ST_PPS_PFX: begin
                if (status.slot_free) begin
                    cmd.op = ans_pkg::OP_EMIT_LONG_PFX;
                    if (status.rep_pfx4_end) begin
                        state_next = ST_PPS_DATA;
                    end
                end
            end
            ST_PPS_DATA: begin
                if (status.slot_free) begin
                    cmd.op = ans_pkg::OP_EMIT_PPS;
                    if (status.rep_pps_end) begin
                        state_next = ST_PFX;
                    end
                end
            end
            ST_PFX: begin
                if (status.slot_free) begin
                    cmd.op = ans_pkg::OP_EMIT_PFX;
                    if (status.rep_pfx_end) begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_HDR: begin
                if (status.slot_free) begin
                    cmd.op     = ans_pkg::OP_EMIT_HDR;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // header byte always closes the forwarded prefix sequence
    a_hdr_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HDR && status.slot_free) |=> (state_reg == ST_IDLE))
        else $error("header emit did not return to idle");

endmodule

`default_nettype wire

@@ hw/rtl/ans_dp.sv @@
// parse state, parameter set stores and result queue of the nal splitter
`default_nettype none

module ans_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_data_byte,
    input  ans_pkg::cmd_t       cmd,
    output ans_pkg::status_t    status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_unit_start,
    output logic                m_unit_end,
    output logic                m_param_overflow,
    output logic                m_last
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unit_start;
        logic       unit_end;
        logic       param_overflow;
        logic       last;
    } res_t;

    ans_pkg::mode_t              mode_reg, mode_next;
    logic [1:0]                  zero_run_reg, zero_run_next;
    logic                        prefix_long_reg, prefix_long_next;
    logic [ans_pkg::SPS_LW-1:0]  sps_len_reg, sps_len_next;
    logic [ans_pkg::PPS_LW-1:0]  pps_len_reg, pps_len_next;
    logic                        sps_valid_reg, sps_valid_next;
    logic                        pps_valid_reg, pps_valid_next;
    logic [ans_pkg::REP_W-1:0]   rep_reg, rep_next;
    logic                        first_reg, first_next;
    logic [7:0]                  byte_reg;

    logic [7:0] sps_mem [ans_pkg::SPS_DEPTH];
    logic [7:0] pps_mem [ans_pkg::PPS_DEPTH];
    // store read data, fetched at the next replay index
    logic [7:0] sps_rd_reg;
    logic [7:0] pps_rd_reg;

    res_t q0_reg, q0_next, q1_reg, q1_next;
    logic q0_valid_reg, q0_valid_next, q1_valid_reg, q1_valid_next;

    logic [7:0]                  cur_byte;
    logic                        emit;
    res_t                        res;
    logic                        dv_en;
    logic [7:0]                  dv_val;
    logic                        dv_last;
    logic                        sps_we;
    logic [ans_pkg::SPS_AW-1:0]  sps_waddr;
    logic [7:0]                  sps_wdata;
    logic                        pps_we;
    logic [ans_pkg::PPS_AW-1:0]  pps_waddr;
    logic [7:0]                  pps_wdata;
    logic                        pop;
    logic                        rep_pfx4_end;
    logic                        rep_sps_end;
    logic                        rep_pps_end;
    logic                        rep_pfx_end;

    assign cur_byte = cmd.take ? s_data_byte : byte_reg;

    assign rep_pfx4_end = (rep_reg == ans_pkg::REP_W'(ans_pkg::PFX_LONG_LAST));
    assign rep_pfx_end  = (rep_reg == (prefix_long_reg ?
                                       ans_pkg::REP_W'(ans_pkg::PFX_LONG_LAST) :
                                       ans_pkg::REP_W'(ans_pkg::PFX_SHORT_LAST)));
    assign rep_sps_end  = ((ans_pkg::CMP_W'(rep_reg) + ans_pkg::CMP_W'(1))
                           == ans_pkg::CMP_W'(sps_len_reg));
    assign rep_pps_end  = ((ans_pkg::CMP_W'(rep_reg) + ans_pkg::CMP_W'(1))
                           == ans_pkg::CMP_W'(pps_len_reg));

    assign status.mode         = mode_reg;
    assign status.zero_run     = zero_run_reg;
    assign status.sps_valid    = sps_valid_reg;
    assign status.pps_valid    = pps_valid_reg;
    assign status.slot_free    = !q1_valid_reg;
    assign status.rep_pfx4_end = rep_pfx4_end;
    assign status.rep_sps_end  = rep_sps_end;
    assign status.rep_pps_end  = rep_pps_end;
    assign status.rep_pfx_end  = rep_pfx_end;

    always_comb begin
        mode_next        = mode_reg;
        zero_run_next    = zero_run_reg;
        prefix_long_next = prefix_long_reg;
        sps_len_next     = sps_len_reg;
        pps_len_next     = pps_len_reg;
        sps_valid_next   = sps_valid_reg;
        pps_valid_next   = pps_valid_reg;
        rep_next         = rep_reg;
        first_next       = first_reg;
        emit             = 1'b0;
        res              = '0;
        dv_en            = 1'b0;
        dv_val           = ans_pkg::BYTE_ZERO;
        dv_last          = 1'b0;
        sps_we           = 1'b0;
        sps_waddr        = '0;
        sps_wdata        = cur_byte;
        pps_we           = 1'b0;
        pps_waddr        = '0;
        pps_wdata        = cur_byte;

        case (cmd.op)
            ans_pkg::OP_START: begin
                if (mode_reg == ans_pkg::MODE_FWD) begin
                    emit         = 1'b1;
                    res.unit_end = 1'b1;
                    res.last     = 1'b1;
                end else if (mode_reg == ans_pkg::MODE_SPS) begin
                    sps_valid_next = 1'b1;
                end else if (mode_reg == ans_pkg::MODE_PPS) begin
                    pps_valid_next = 1'b1;
                end
                prefix_long_next = (zero_run_reg == ans_pkg::ZERO_RUN_MAX);
                zero_run_next    = 2'd0;
                mode_next        = ans_pkg::MODE_HEAD;
            end
            ans_pkg::OP_HEAD_ZERO: begin
                mode_next     = ans_pkg::MODE_SKIP;
                zero_run_next = 2'd1;
            end
            ans_pkg::OP_HEAD_BEGIN: begin
                first_next = 1'b1;
                rep_next   = '0;
            end
            ans_pkg::OP_HEAD_OTHER: begin
                case (ans_pkg::nal_type(cur_byte))
                    ans_pkg::TYPE_SPS: begin
                        sps_valid_next = 1'b0;
                        sps_we         = 1'b1;
                        sps_len_next   = ans_pkg::SPS_LW'(1);
                        mode_next      = ans_pkg::MODE_SPS;
                    end
                    ans_pkg::TYPE_PPS: begin
                        pps_valid_next = 1'b0;
                        pps_we         = 1'b1;
                        pps_len_next   = ans_pkg::PPS_LW'(1);
                        mode_next      = ans_pkg::MODE_PPS;
                    end
                    default: begin
                        mode_next = ans_pkg::MODE_SKIP;
                    end
                endcase
            end
            ans_pkg::OP_ZERO: begin
                if (zero_run_reg != ans_pkg::ZERO_RUN_MAX) begin
                    zero_run_next = zero_run_reg + 2'd1;
                end else begin
                    dv_en   = 1'b1;
                    dv_last = 1'b1;
                end
            end
            ans_pkg::OP_DELIV_ZERO: begin
                zero_run_next = zero_run_reg - 2'd1;
                dv_en         = 1'b1;
            end
            ans_pkg::OP_DELIV_BYTE: begin
                zero_run_next = 2'd0;
                dv_en         = 1'b1;
                dv_val        = cur_byte;
                dv_last       = 1'b1;
            end
            ans_pkg::OP_EMIT_LONG_PFX: begin
                emit           = 1'b1;
                res.out_byte   = rep_pfx4_end ? ans_pkg::BYTE_ONE : ans_pkg::BYTE_ZERO;
                res.byte_valid = 1'b1;
                res.unit_start = first_reg;
                first_next     = 1'b0;
                rep_next       = rep_pfx4_end ? '0 : rep_reg + 1'b1;
            end
            ans_pkg::OP_EMIT_SPS: begin
                emit           = 1'b1;
                res.out_byte   = sps_rd_reg;
                res.byte_valid = 1'b1;
                res.unit_start = first_reg;
                first_next     = 1'b0;
                rep_next       = rep_sps_end ? '0 : rep_reg + 1'b1;
            end
            ans_pkg::OP_EMIT_PPS: begin
                emit           = 1'b1;
                res.out_byte   = pps_rd_reg;
                res.byte_valid = 1'b1;
                res.unit_start = first_reg;
                first_next     = 1'b0;
                rep_next       = rep_pps_end ? '0 : rep_reg + 1'b1;
            end
            ans_pkg::OP_EMIT_PFX: begin
                emit           = 1'b1;
                res.out_byte   = rep_pfx_end ? ans_pkg::BYTE_ONE : ans_pkg::BYTE_ZERO;
                res.byte_valid = 1'b1;
                res.unit_start = first_reg;
                first_next     = 1'b0;
                rep_next       = rep_pfx_end ? '0 : rep_reg + 1'b1;
            end
            ans_pkg::OP_EMIT_HDR: begin
                emit           = 1'b1;
                res.out_byte   = byte_reg;
                res.byte_valid = 1'b1;
                res.unit_start = first_reg;
                res.last       = 1'b1;
                first_next     = 1'b0;
                mode_next      = ans_pkg::MODE_FWD;
            end
            default: begin
            end
        endcase

        // payload byte goes out, into a store, trips the overflow, or is dropped
        if (dv_en) begin
            if (mode_reg == ans_pkg::MODE_FWD) begin
                emit           = 1'b1;
                res.out_byte   = dv_val;
                res.byte_valid = 1'b1;
                res.last       = dv_last;
            end else if (mode_reg == ans_pkg::MODE_SPS) begin
                if (sps_len_reg >= ans_pkg::SPS_LW'(ans_pkg::SPS_DEPTH)) begin
                    sps_valid_next     = 1'b0;
                    mode_next          = ans_pkg::MODE_SKIP;
                    emit               = 1'b1;
                    res.param_overflow = 1'b1;
                    res.last           = 1'b1;
                end else begin
                    sps_we       = 1'b1;
                    sps_waddr    = sps_len_reg[ans_pkg::SPS_AW-1:0];
                    sps_wdata    = dv_val;
                    sps_len_next = sps_len_reg + 1'b1;
                end
            end else if (mode_reg == ans_pkg::MODE_PPS) begin
                if (pps_len_reg >= ans_pkg::PPS_LW'(ans_pkg::PPS_DEPTH)) begin
                    pps_valid_next     = 1'b0;
                    mode_next          = ans_pkg::MODE_SKIP;
                    emit               = 1'b1;
                    res.param_overflow = 1'b1;
                    res.last           = 1'b1;
                end else begin
                    pps_we       = 1'b1;
                    pps_waddr    = pps_len_reg[ans_pkg::PPS_AW-1:0];
                    pps_wdata    = dv_val;
                    pps_len_next = pps_len_reg + 1'b1;
                end
            end
        end
    end

    // two-entry result queue
    assign pop = q0_valid_reg && m_ready;

    always_comb begin
        q0_next       = q0_reg;
        q1_next       = q1_reg;
        q0_valid_next = q0_valid_reg;
        q1_valid_next = q1_valid_reg;
        if (pop) begin
            if (q1_valid_reg) begin
                q0_next       = q1_reg;
                q1_valid_next = 1'b0;
            end else begin
                q0_valid_next = 1'b0;
            end
        end
        if (emit) begin
            if (!q0_valid_next) begin
                q0_next       = res;
                q0_valid_next = 1'b1;
            end else begin
                q1_next       = res;
                q1_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= ans_pkg::MODE_SKIP;
            zero_run_reg    <= 2'd0;
            prefix_long_reg <= 1'b0;
            sps_len_reg     <= '0;
            pps_len_reg     <= '0;
            sps_valid_reg   <= 1'b0;
            pps_valid_reg   <= 1'b0;
            rep_reg         <= '0;
            first_reg       <= 1'b0;
            q0_valid_reg    <= 1'b0;
            q1_valid_reg    <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            zero_run_reg    <= zero_run_next;
            prefix_long_reg <= prefix_long_next;
            sps_len_reg     <= sps_len_next;
            pps_len_reg     <= pps_len_next;
            sps_valid_reg   <= sps_valid_next;
            pps_valid_reg   <= pps_valid_next;
            rep_reg         <= rep_next;
            first_reg       <= first_next;
            q0_valid_reg    <= q0_valid_next;
            q1_valid_reg    <= q1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        if (cmd.take) begin
            byte_reg <= s_data_byte;
        end
    end

    // read data follows rep_next, so it holds the entry at rep_reg during replay;
    // stores are never written while a replay runs
    always_ff @(posedge aclk) begin
        if (sps_we) begin
            sps_mem[sps_waddr] <= sps_wdata;
        end
        if (pps_we) begin
            pps_mem[pps_waddr] <= pps_wdata;
        end
        sps_rd_reg <= sps_mem[rep_next[ans_pkg::SPS_AW-1:0]];
        pps_rd_reg <= pps_mem[rep_next[ans_pkg::PPS_AW-1:0]];
    end

    assign m_valid          = q0_valid_reg;
    assign m_out_byte       = q0_reg.out_byte;
    assign m_byte_valid     = q0_reg.byte_valid;
    assign m_unit_start     = q0_reg.unit_start;
    assign m_unit_end       = q0_reg.unit_end;
    assign m_param_overflow = q0_reg.param_overflow;
    assign m_last           = q0_reg.last;

    a_sps_len: assert property (@(posedge aclk) disable iff (!aresetn)
        sps_valid_reg |-> (sps_len_reg != '0))
        else $error("valid sps with empty store");

    a_head_zero_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == ans_pkg::MODE_HEAD) |-> (zero_run_reg == 2'd0))
        else $error("zeros held while waiting for a header");

    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_param_overflow) |-> (m_last && !m_byte_valid))
        else $error("overflow marker not the final result of its item");

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        q1_valid_reg |-> q0_valid_reg)
        else $error("queue tail filled with empty head");

endmodule

`default_nettype wire

@@ hw/rtl/annexb_nal_splitter.sv @@
// top level of the annex b nal unit splitter
`default_nettype none

// channel   direction  ports                                   payload
// s_        in         s_valid s_ready s_data_byte             one stream byte
// m_        out        m_valid m_ready m_out_byte m_byte_valid  one output byte
//                      m_unit_start m_unit_end                  or one marker
//                      m_param_overflow m_last
//
// a byte that releases held zeros first delivers each held zero in turn
// a slice header runs take, prefix, header byte; an idr header runs take, each
// valid set behind a 4-byte prefix, prefix, header byte; one result per cycle
// while a queue slot is free, from the sequencer into a two-entry result queue
// reset is synchronous active low and leaves no parameter set valid
// input is taken only in the idle state with a free queue slot, so a full
// queue (m_ready low) stalls the parser; stores need no clearing pass
module annexb_nal_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_unit_start,
    output logic        m_unit_end,
    output logic        m_param_overflow,
    output logic        m_last
);

    // command from the sequencer, status back from the datapath
    ans_pkg::cmd_t    cmd;
    ans_pkg::status_t status;

    // sequencer: decodes each item and steps through prefix and replay bursts
    ans_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_data_byte (s_data_byte),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // datapath: zero run tracking, sps/pps stores and the result queue
    ans_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_data_byte      (s_data_byte),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_unit_start     (m_unit_start),
        .m_unit_end       (m_unit_end),
        .m_param_overflow (m_param_overflow),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

@@ sim/annexb_nal_splitter_test.sv @@
// testbench for annexb_nal_splitter: random annex b streams checked against a byte-level parser
`timescale 1ns / 100ps

module annexb_nal_splitter_test;
    import ans_pkg::*;

    // header types used by the stimulus besides the package ones
    localparam logic [4:0] TYPE_TOP = 5'd31;

    // long receiver hold-off, long enough to fill the result queue and stall input
    localparam int LONG_HOLD = 300;
    // stimulus split over the three idling phases
    localparam int PHASE0_END = 160;
    localparam int PHASE1_END = 320;
    localparam int ITEMS_TOTAL = 470;
    // settle time after the last result, well past the deepest idr replay
    localparam int SETTLE_CYCLES = 80;

    // one result of the block, in port order
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unit_start;
        logic       unit_end;
        logic       param_overflow;
        logic       last;
    } splitter_out_t;

    // software copy of the splitter: parses the byte stream and queues the results it owes
    class splitter_mirror;
        splitter_out_t pending_out[$];
        splitter_out_t step_out[$];

        mode_t      mode;
        logic [1:0] zeros_held;
        logic       long_start;
        logic [7:0] sps_bytes[SPS_DEPTH];
        logic [5:0] sps_count;
        logic       sps_live;
        logic [7:0] pps_bytes[PPS_DEPTH];
        logic [4:0] pps_count;
        logic       pps_live;

        int errors;
        int bytes_in;
        int results_seen;
        int starts_seen;
        int ends_seen;
        int overflows_seen;
        int idr_replays;

        function new();
            mode = MODE_SKIP;
            zeros_held = '0;
            long_start = 1'b0;
            sps_count = '0;
            sps_live = 1'b0;
            pps_count = '0;
            pps_live = 1'b0;
        endfunction

        function int pending();
            return pending_out.size();
        endfunction

        function void emit(logic [7:0] b, logic valid, logic opens, logic ends, logic ovf);
            splitter_out_t r;
            r.out_byte = b;
            r.byte_valid = valid;
            r.unit_start = opens && (step_out.size() == 0);
            r.unit_end = ends;
            r.param_overflow = ovf;
            r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        function void emit_long_prefix();
            emit(BYTE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0);
            emit(BYTE_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
            emit(BYTE_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
            emit(BYTE_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        endfunction

        // payload byte: forwarded, stored, or dropped depending on the current unit
        function void store_byte(logic [7:0] b);
            case (mode)
                MODE_FWD: emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
                MODE_SPS: begin
                    if (sps_count >= SPS_DEPTH) begin
                        sps_live = 1'b0;
                        mode = MODE_SKIP;
                        emit(BYTE_ZERO, 1'b0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        sps_bytes[sps_count] = b;
                        sps_count++;
                    end
                end
                MODE_PPS: begin
                    if (pps_count >= PPS_DEPTH) begin
                        pps_live = 1'b0;
                        mode = MODE_SKIP;
                        emit(BYTE_ZERO, 1'b0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        pps_bytes[pps_count] = b;
                        pps_count++;
                    end
                end
                default: ;
            endcase
        endfunction

        // unit header byte right after a start code
        function void open_unit(logic [7:0] b);
            logic [4:0] kind;
            int i;
            kind = b[4:0];
            if (kind == TYPE_SLICE || kind == TYPE_IDR) begin
                if (kind == TYPE_IDR) begin
                    idr_replays++;
                    if (sps_live) begin
                        emit_long_prefix();
                        for (i = 0; i < sps_count; i++)
                            emit(sps_bytes[i], 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                    if (pps_live) begin
                        emit_long_prefix();
                        for (i = 0; i < pps_count; i++)
                            emit(pps_bytes[i], 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                end
                if (long_start)
                    emit(BYTE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0);
                emit(BYTE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0);
                emit(BYTE_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
                emit(BYTE_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
                emit(b, 1'b1, 1'b0, 1'b0, 1'b0);
                mode = MODE_FWD;
            end else if (kind == TYPE_SPS) begin
                sps_live = 1'b0;
                sps_bytes[0] = b;
                sps_count = 1;
                mode = MODE_SPS;
            end else if (kind == TYPE_PPS) begin
                pps_live = 1'b0;
                pps_bytes[0] = b;
                pps_count = 1;
                mode = MODE_PPS;
            end else begin
                mode = MODE_SKIP;
            end
        endfunction

        // one accepted stream byte
        function void take_byte(logic [7:0] b);
            int n;
            splitter_out_t r;
            step_out.delete();
            bytes_in++;
            if (b == BYTE_ONE && zeros_held >= 2) begin
                if (mode == MODE_FWD)
                    emit(BYTE_ZERO, 1'b0, 1'b0, 1'b1, 1'b0);
                else if (mode == MODE_SPS)
                    sps_live = 1'b1;
                else if (mode == MODE_PPS)
                    pps_live = 1'b1;
                long_start = (zeros_held == ZERO_RUN_MAX);
                zeros_held = '0;
                mode = MODE_HEAD;
            end else if (mode == MODE_HEAD) begin
                if (b == BYTE_ZERO) begin
                    mode = MODE_SKIP;
                    zeros_held = 2'd1;
                end else begin
                    open_unit(b);
                end
            end else if (b == BYTE_ZERO) begin
                if (zeros_held < ZERO_RUN_MAX)
                    zeros_held++;
                else
                    store_byte(BYTE_ZERO);
            end else begin
                n = zeros_held;
                zeros_held = '0;
                repeat (n) store_byte(BYTE_ZERO);
                store_byte(b);
            end
            if (step_out.size() > 0) begin
                r = step_out.pop_back();
                r.last = 1'b1;
                step_out.push_back(r);
            end
            foreach (step_out[j]) pending_out.push_back(step_out[j]);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // one accepted result against the oldest one owed
        function void match_out(splitter_out_t got);
            splitter_out_t want;
            results_seen++;
            if (got.unit_start) starts_seen++;
            if (got.unit_end) ends_seen++;
            if (got.param_overflow) overflows_seen++;
            if (pending_out.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_out.pop_front();
            compare("out_byte", want.out_byte, got.out_byte);
            compare("byte_valid", want.byte_valid, got.byte_valid);
            compare("unit_start", want.unit_start, got.unit_start);
            compare("unit_end", want.unit_end, got.unit_end);
            compare("param_overflow", want.param_overflow, got.param_overflow);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_unit_start;
    logic       m_unit_end;
    logic       m_param_overflow;
    logic       m_last;

    splitter_mirror tracker;
    splitter_out_t  seen;

    // idle chances in percent, changed per phase
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int items_sent = 0;

    // long hold-off requests from the stimulus, served by the receiver process
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // opening stream: junk before any start code, a four-zero run, a zero header,
    // an idr with no stored sets, zeros released inside a unit, sps and pps stores,
    // an idr replaying both sets behind a 4-byte start code, a dropped type
    logic [7:0] opening[$] = '{
        8'hFF,
        BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
        BYTE_ZERO,
        BYTE_ZERO, BYTE_ONE,
        {3'b011, TYPE_IDR},
        BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 8'h80,
        BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
        {3'b011, TYPE_SPS},
        BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
        {3'b111, TYPE_PPS},
        BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
        {3'b011, TYPE_IDR},
        BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
        {3'b000, TYPE_TOP}
    };

    annexb_nal_splitter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_unit_start     (m_unit_start),
        .m_unit_end       (m_unit_end),
        .m_param_overflow (m_param_overflow),
        .m_last           (m_last)
    );

    always #6 aclk = ~aclk;

    // both handshakes are sampled at the edge, before any driven input moves,
    // so an item is noted before a result of the same edge is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_byte(s_data_byte);
            if (m_valid && m_ready) begin
                seen.out_byte = m_out_byte;
                seen.byte_valid = m_byte_valid;
                seen.unit_start = m_unit_start;
                seen.unit_end = m_unit_end;
                seen.param_overflow = m_param_overflow;
                seen.last = m_last;
                tracker.match_out(seen);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one stream byte and return at the edge that takes it;
    // valid stays high across back-to-back items
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // random payload byte, heavy on zeros and ones to hit zero runs and stray start codes
    function automatic logic [7:0] body_byte();
        case ($urandom_range(9))
            0, 1: return BYTE_ZERO;
            2: return BYTE_ONE;
            default: return 8'($urandom);
        endcase
    endfunction

    // one unit: start code, header, body; now and then plain noise instead
    task automatic send_unit();
        int zeros;
        int body_len;
        int pick;
        logic [4:0] kind;
        if ($urandom_range(9) == 0) begin
            // noise, no framing at all
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            return;
        end
        zeros = ($urandom_range(2) == 0) ? 3 : 2;
        if ($urandom_range(11) == 0)
            zeros += $urandom_range(1, 3);
        repeat (zeros) send_byte(BYTE_ZERO);
        send_byte(BYTE_ONE);
        pick = $urandom_range(99);
        if (pick < 30) begin
            kind = TYPE_SLICE;
            body_len = $urandom_range(0, 10);
        end else if (pick < 50) begin
            kind = TYPE_IDR;
            body_len = $urandom_range(0, 6);
        end else if (pick < 70) begin
            kind = TYPE_SPS;
            // sometimes right around the store size, to hit overflow and the full set
            body_len = ($urandom_range(5) == 0) ? $urandom_range(SPS_DEPTH - 3, SPS_DEPTH + 6)
                                                : $urandom_range(0, 12);
        end else if (pick < 90) begin
            kind = TYPE_PPS;
            body_len = ($urandom_range(5) == 0) ? $urandom_range(PPS_DEPTH - 3, PPS_DEPTH + 6)
                                                : $urandom_range(0, 8);
        end else begin
            // any type, the zero header and the dropped ones among them
            kind = 5'($urandom);
            body_len = $urandom_range(0, 6);
        end
        send_byte({3'($urandom), kind});
        repeat (body_len) begin
            if ($urandom_range(15) == 0)
                repeat ($urandom_range(3, 5)) send_byte(BYTE_ZERO);
            send_byte(body_byte());
        end
    endtask

    // stop offering and wait for every owed result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    initial begin
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 0: sender idles a quarter of the time, receiver about half
        src_idle_pct = 25;
        sink_idle_pct = 48;
        foreach (opening[i]) send_byte(opening[i]);
        while (items_sent < PHASE0_END) send_unit();
        // sender pause until the block has handed back everything
        drain();

        // phase 1: roles swapped, with one long receiver hold-off while bytes keep coming
        src_idle_pct = 48;
        sink_idle_pct = 25;
        hold_requests++;
        while (items_sent < PHASE1_END) send_unit();

        // phase 2: full rate on both sides
        src_idle_pct = 0;
        sink_idle_pct = 0;
        while (items_sent < ITEMS_TOTAL) send_unit();

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d stream bytes, %0d results, %0d idr headers",
                 tracker.bytes_in, tracker.results_seen, tracker.idr_replays);
        $display("seen %0d unit starts, %0d unit ends, %0d store overflows",
                 tracker.starts_seen, tracker.ends_seen, tracker.overflows_seen);
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", tracker.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: a correct run needs far less than a tenth of this
    initial begin
        #10_000_000;
        $display("timeout with %0d results still owed", tracker.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
